@@ hdl/ttrc_pkg.sv @@
// Shared constants for the three-term recurrence checksum.
// Used by ttrc_term and three_term_recurrence_checksum. No dependencies.
`timescale 1ns / 1ps

package ttrc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TERM_W = 16;
  localparam int unsigned PROD_W = 25;   // 9-bit factor times 16-bit term
  localparam int unsigned SUB_W  = 24;   // 8-bit beta times 16-bit term
  localparam int unsigned SUM_W  = 26;   // biased difference before the fold

  localparam logic [BYTE_W-1:0] FIRST_OFFSET = 8'd7;
  localparam logic [BYTE_W-1:0] ALPHA_MUL    = 8'd17;
  localparam logic [BYTE_W-1:0] BETA_MUL     = 8'd31;
  localparam logic [TERM_W-1:0] TERM_MOD     = 16'hFFFF;
  localparam logic [TERM_W-1:0] TERM_RESET   = 16'd1;
  // 256 * 65535: a multiple of the modulus that covers the largest subtrahend
  localparam logic [SUM_W-1:0]  DIFF_BIAS    = 26'd16776960;

endpackage

@@ hdl/ttrc_term.sv @@
// Next-term datapath of the recurrence: two small multiplies and a mod-65535 fold.
// Combinational. Depends on ttrc_pkg.
`timescale 1ns / 1ps

module ttrc_term
  import ttrc_pkg::*;
(
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [BYTE_W-1:0] position,
  input  logic [TERM_W-1:0] cur_term,
  input  logic [TERM_W-1:0] prev_term,
  output logic [TERM_W-1:0] next_term
);

  logic [BYTE_W-1:0] alpha;
  logic [BYTE_W-1:0] beta;
  logic [8:0]        factor;
  logic [PROD_W-1:0] prod;
  logic [SUB_W-1:0]  sub;
  logic              neg;
  logic [SUM_W-1:0]  diff;
  logic [16:0]       fold;

  always_comb begin
    // mod 256 is just the low byte of the product
    alpha  = BYTE_W'(position * ALPHA_MUL);
    beta   = BYTE_W'(position * BETA_MUL);
    factor = {1'b0, data_byte} + {1'b0, alpha};
    prod   = PROD_W'(factor) * PROD_W'(cur_term);
    sub    = SUB_W'(beta) * SUB_W'(prev_term);
    // a negative difference wraps through 2^64, and 2^64 = 1 mod 65535
    neg    = prod < PROD_W'(sub);
    diff   = SUM_W'(prod) + DIFF_BIAS - SUM_W'(sub) + SUM_W'(neg);
    // 65536 = 1 mod 65535: add high part to low part, then one correction
    fold   = 17'(diff[SUM_W-1:16]) + 17'(diff[15:0]);
    if (fold >= 17'(TERM_MOD)) begin
      fold = fold - 17'(TERM_MOD);
    end
    next_term = fold[TERM_W-1:0];
  end

endmodule

@@ hdl/three_term_recurrence_checksum.sv @@
// Three-term recurrence checksum, top level: input register, term update, output register.
// Depends on ttrc_pkg and ttrc_term.
`timescale 1ns / 1ps

// One message byte per input beat, tlast on the final byte. Each byte is
// registered, then the next recurrence term is formed in the following cycle
// from the stored terms; on the final byte the checksum goes to the output
// register and the term state returns to its reset values, so the next beat
// starts a new message. A new byte is taken every cycle; a final byte passes
// through the input register, then the output register. The term update (two
// narrow multiplies and a mod-65535 fold) sets the clock limit. Output
// backpressure stalls input only when a checksum is waiting to leave.
module three_term_recurrence_checksum
  import ttrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // [15:0] checksum
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [TERM_W-1:0] out_sum_r, out_sum_nxt;
  logic [TERM_W-1:0] prev_r, prev_nxt;
  logic [TERM_W-1:0] cur_r, cur_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic              started_r, started_nxt;
  logic [TERM_W-1:0] term_calc;
  logic [TERM_W-1:0] term_new;
  logic              s1_adv;
  logic              in_acc;

  ttrc_term u_term (
    .data_byte (s1_byte_r),
    .position  (pos_r),
    .cur_term  (cur_r),
    .prev_term (prev_r),
    .next_term (term_calc)
  );

  always_comb begin
    // a registered byte moves on unless it carries a checksum that cannot land
    s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
    in_tready = !s1_valid_r || s1_adv;
    in_acc    = in_tvalid && in_tready;

    term_new = started_r ? term_calc : TERM_W'({1'b0, s1_byte_r} + {1'b0, FIRST_OFFSET});

    s1_valid_nxt = in_acc || (s1_valid_r && !s1_adv);

    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        prev_nxt    = TERM_RESET;
        cur_nxt     = TERM_RESET;
        pos_nxt     = '0;
        started_nxt = 1'b0;
      end else begin
        prev_nxt    = started_r ? cur_r : TERM_RESET;
        cur_nxt     = term_new;
        pos_nxt     = pos_r + 1'b1;
        started_nxt = 1'b1;
      end
    end

    out_valid_nxt = out_valid_r && !out_tready;
    out_sum_nxt   = out_sum_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = term_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= TERM_RESET;
      cur_r       <= TERM_RESET;
      pos_r       <= '0;
      started_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      cur_r       <= cur_nxt;
      pos_r       <= pos_nxt;
      started_r   <= started_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    out_sum_r <= out_sum_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;

endmodule

@@ test/tb_three_term_recurrence_checksum.sv @@
// Testbench for three_term_recurrence_checksum: directed and random messages are
// checked against a bit-exact recurrence predictor, with input bursts and output stalls.
// Depends on ttrc_pkg and the three_term_recurrence_checksum RTL.
`timescale 1ns / 1ps

module tb_three_term_recurrence_checksum;
  import ttrc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] data_byte
  logic        in_tlast   = 1'b0;  // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] checksum

  three_term_recurrence_checksum dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Predictor state, mirrors the block's term registers
  logic [TERM_W-1:0] term_prev = TERM_RESET;
  logic [TERM_W-1:0] term_cur  = TERM_RESET;
  logic [BYTE_W-1:0] byte_pos  = '0;
  logic              msg_open  = 1'b0;
  logic [TERM_W-1:0] pending_checksums[$];

  int unsigned burst_left     = 0;
  int unsigned stall_hold     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  logic [TERM_W-1:0] want_sum;

  task automatic advance_recurrence(input logic [7:0] b, input logic l);
    longint unsigned pos, alpha, beta, prod, sub, nxt;
    if (!msg_open) begin
      term_cur  = {8'd0, b} + {8'd0, FIRST_OFFSET};
      term_prev = TERM_RESET;
      byte_pos  = 8'd1;
      msg_open  = 1'b1;
    end else begin
      pos   = 64'(byte_pos);
      alpha = (pos * ALPHA_MUL) % 64'd256;
      beta  = (pos * BETA_MUL) % 64'd256;
      prod  = (b + alpha) * term_cur;
      sub   = beta * term_prev;
      // difference wraps at 64 bits before the fold
      nxt   = (prod - sub) % {48'd0, TERM_MOD};
      term_prev = term_cur;
      term_cur  = nxt[TERM_W-1:0];
      byte_pos  = byte_pos + 8'd1;
    end
    if (l) begin
      pending_checksums.push_back(term_cur);
      term_prev = TERM_RESET;
      term_cur  = TERM_RESET;
      byte_pos  = '0;
      msg_open  = 1'b0;
    end
  endtask

  // One input beat; the sender runs in bursts with idle gaps between them
  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_recurrence(b, l);
    burst_left--;
  endtask

  task automatic send_random_message(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic test_one_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_short_message_extremes();
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
  endtask

  // Past 256 bytes the position counter wraps and alpha, beta go back to zero
  task automatic test_position_wrap();
    send_random_message($urandom_range(257, 300));
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
      send_random_message(len);
      sent += len;
    end
  endtask

  function automatic void note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("checksum mismatch (%s): expected %0d, got %0d", what, want, got);
  endfunction

  // Receiver: long ready stretches, stalls of random length, and choppy stretches
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_tready <= 1'b1;
          stall_hold = $urandom_range(20, 60);
        end
        1: begin
          out_tready <= 1'b0;
          stall_hold = $urandom_range(1, 15);
        end
        default: begin
          out_tready <= 1'($urandom_range(0, 1));
          stall_hold = 0;
        end
      endcase
    end else begin
      stall_hold--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_checksums.size() == 0) begin
        note_mismatch("no checksum expected", 16'd0, out_tdata);
      end else begin
        want_sum = pending_checksums.pop_front();
        if (out_tdata !== want_sum) note_mismatch("checksum", want_sum, out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_three_term_recurrence_checksum: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_one_byte_messages();
    test_short_message_extremes();
    test_position_wrap();
    test_random_messages();
    in_tvalid <= 1'b0;
    while (pending_checksums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_checksums.size() == 0) begin
      $display("tb_three_term_recurrence_checksum: clean");
    end else begin
      $display("tb_three_term_recurrence_checksum: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ttrc_pkg.sv
hdl/ttrc_term.sv
hdl/three_term_recurrence_checksum.sv
test/tb_three_term_recurrence_checksum.sv
